// ===== hw/rtl/bop_pkg.sv =====
package bop_pkg;

    localparam int PRICE_W  = 32;
    localparam int FRAC_Q30 = 30;
    localparam int MAX_STEPS = 1024;
    localparam int IDX_W    = 11;
    localparam int ROW_DEPTH = MAX_STEPS + 1;
    localparam int ADDR_W   = 5;

    localparam logic [IDX_W-1:0]   MAX_STEPS_V = IDX_W'(MAX_STEPS);
    localparam logic [30:0]        Q30_ONE     = 31'h4000_0000;

    // register indexes
    localparam logic [2:0] REG_UP_FACTOR   = 3'd0;
    localparam logic [2:0] REG_DOWN_FACTOR = 3'd1;
    localparam logic [2:0] REG_UP_PROB     = 3'd2;
    localparam logic [2:0] REG_DISCOUNT    = 3'd3;
    localparam logic [2:0] REG_STEP_COUNT  = 3'd4;
    localparam logic [2:0] REG_OPTION_KIND = 3'd5;

    localparam logic [1:0] KIND_EURO_CALL = 2'd0;
    localparam logic [1:0] KIND_EURO_PUT  = 2'd1;
    localparam logic [1:0] KIND_AMER_CALL = 2'd2;
    localparam logic [1:0] KIND_AMER_PUT  = 2'd3;

    localparam logic [IDX_W-1:0] STEP_COUNT_RESET = 11'd30;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_DOWN,
        OP_DOWN_END,
        OP_LEAF,
        OP_UP,
        OP_LDEC,
        OP_LV,
        OP_LV2,
        OP_RD,
        OP_MP,
        OP_MQ,
        OP_SUM,
        OP_DISC,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_eq_n;
        logic cnt_eq_lvl;
        logic lvl_zero;
        logic american;
        logic out_free;
    } dp_status_t;

    // round(a*b / 2^30), saturated; bit 32 flags saturation
    function automatic logic [PRICE_W:0] mul_q30(input logic [PRICE_W-1:0] a,
                                                 input logic [31:0] b);
        logic [PRICE_W+31:0] prod;
        logic [PRICE_W+32:0] sum;
        logic [PRICE_W+2:0]  res;
        begin
            prod = a * b;
            sum  = {1'b0, prod} + (PRICE_W+33)'(1 << (FRAC_Q30 - 1));
            res  = sum[PRICE_W+32:FRAC_Q30];
            if (res[PRICE_W+2:PRICE_W] != 3'd0)
                mul_q30 = {1'b1, {PRICE_W{1'b1}}};
            else
                mul_q30 = {1'b0, res[PRICE_W-1:0]};
        end
    endfunction

    function automatic logic [PRICE_W-1:0] payoff(input logic [PRICE_W-1:0] price,
                                                  input logic [PRICE_W-1:0] strike,
                                                  input logic is_put);
        begin
            if (is_put)
                payoff = (strike > price) ? strike - price : '0;
            else
                payoff = (price > strike) ? price - strike : '0;
        end
    endfunction

endpackage

// ===== hw/rtl/bop_ctrl.sv =====
module bop_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bop_pkg::dp_status_t status,
    output bop_pkg::dp_cmd_t    cmd
);
    import bop_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DOWN, S_LEAF, S_UP1, S_UP2, S_LDEC, S_LV, S_LV2,
        S_RD, S_MP, S_MQ, S_SUM, S_DISC, S_UP3, S_UP4, S_FIN
    } state_t;

    state_t state_reg, state_next;
    dp_op_t op;

    assign in_stall = (state_reg != S_IDLE);
    assign cmd.op   = op;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_START;
                    state_next = S_DOWN;
                end
            end
            S_DOWN:
            begin
                if (status.cnt_eq_n)
                begin
                    op         = OP_DOWN_END;
                    state_next = S_LEAF;
                end
                else
                    op = OP_DOWN;
            end
            S_LEAF:
            begin
                op         = OP_LEAF;
                state_next = status.cnt_eq_n ? S_LDEC : S_UP1;
            end
            S_UP1:
            begin
                op         = OP_UP;
                state_next = S_UP2;
            end
            S_UP2:
            begin
                op         = OP_UP;
                state_next = S_LEAF;
            end
            S_LDEC:
            begin
                op         = OP_LDEC;
                state_next = S_LV;
            end
            S_LV:
            begin
                op         = OP_LV;
                state_next = S_LV2;
            end
            S_LV2:
            begin
                op         = OP_LV2;
                state_next = S_RD;
            end
            S_RD:
            begin
                op         = OP_RD;
                state_next = S_MP;
            end
            S_MP:
            begin
                op         = OP_MP;
                state_next = S_MQ;
            end
            S_MQ:
            begin
                op         = OP_MQ;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                op         = OP_SUM;
                state_next = S_DISC;
            end
            S_DISC:
            begin
                op = OP_DISC;
                if (status.cnt_eq_lvl)
                    state_next = status.lvl_zero ? S_FIN : S_LDEC;
                else
                    state_next = status.american ? S_UP3 : S_RD;
            end
            S_UP3:
            begin
                op         = OP_UP;
                state_next = S_UP4;
            end
            S_UP4:
            begin
                op         = OP_UP;
                state_next = S_RD;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    op         = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/bop_datapath.sv =====
module bop_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bop_pkg::dp_cmd_t           cmd,
    output bop_pkg::dp_status_t        status,
    input  logic [31:0]                spot_price,
    input  logic [31:0]                strike_price,
    input  logic [31:0]                up_factor,
    input  logic [31:0]                down_factor,
    input  logic [30:0]                up_probability,
    input  logic [30:0]                step_discount,
    input  logic [10:0]                step_count,
    input  logic [1:0]                 option_kind,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic [31:0]                option_value,
    output logic                       saturated
);
    import bop_pkg::*;

    logic [PRICE_W-1:0] row_mem [ROW_DEPTH];
    logic [PRICE_W-1:0] bot_mem [ROW_DEPTH];
    logic [PRICE_W-1:0] row_rdata_reg, bot_rdata_reg;

    logic [PRICE_W-1:0] price_reg, strike_reg, up_reg, down_reg;
    logic [PRICE_W-1:0] t1_reg, t2_reg, ev_reg, root_reg;
    logic [IDX_W-1:0]   cnt_reg, lvl_reg, n_reg;
    logic               flag_reg, out_valid_reg, out_flag_reg;
    logic [31:0]        out_value_reg;

    logic [IDX_W-1:0]   n_clamped;
    logic [30:0]        p_clamped, q_val;
    logic [PRICE_W-1:0] mul_a;
    logic [31:0]        mul_b;
    logic [PRICE_W:0]   mul_r;
    logic [PRICE_W:0]   sum_r;
    logic [PRICE_W-1:0] ex_val, node_val;
    logic               is_put, american;
    logic [IDX_W-1:0]   row_raddr;

    assign is_put   = option_kind[0];
    assign american = option_kind[1];

    assign n_clamped = (step_count == '0) ? IDX_W'(1)
                     : (step_count > MAX_STEPS_V) ? MAX_STEPS_V : step_count;
    assign p_clamped = (up_probability > Q30_ONE) ? Q30_ONE : up_probability;
    assign q_val     = Q30_ONE - p_clamped;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = price_reg;
        mul_b = up_factor;
        case (cmd.op)
            OP_DOWN: mul_b = down_factor;
            OP_MP:
            begin
                mul_a = row_rdata_reg;
                mul_b = {1'b0, p_clamped};
            end
            OP_MQ:
            begin
                mul_a = down_reg;
                mul_b = {1'b0, q_val};
            end
            OP_DISC:
            begin
                mul_a = ev_reg;
                mul_b = {1'b0, step_discount};
            end
            default: ;
        endcase
    end

    assign mul_r    = mul_q30(mul_a, mul_b);
    assign sum_r    = {1'b0, t1_reg} + {1'b0, t2_reg};
    assign ex_val   = payoff(price_reg, strike_reg, is_put);
    assign node_val = (american && (ex_val > mul_r[PRICE_W-1:0])) ? ex_val
                                                                   : mul_r[PRICE_W-1:0];
    assign row_raddr = (cmd.op == OP_RD) ? cnt_reg + IDX_W'(1) : '0;

    // value row and bottom price memories
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LEAF)
            row_mem[cnt_reg] <= payoff(price_reg, strike_reg, is_put);
        else if (cmd.op == OP_DISC)
            row_mem[cnt_reg] <= node_val;
        row_rdata_reg <= row_mem[row_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DOWN)
            bot_mem[cnt_reg] <= price_reg;
        bot_rdata_reg <= bot_mem[lvl_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_START:
            begin
                price_reg  <= spot_price;
                strike_reg <= strike_price;
                n_reg      <= n_clamped;
            end
            OP_DOWN, OP_UP: price_reg <= mul_r[PRICE_W-1:0];
            OP_LV2:
            begin
                down_reg  <= row_rdata_reg;
                price_reg <= bot_rdata_reg;
            end
            OP_MP:
            begin
                t1_reg <= mul_r[PRICE_W-1:0];
                up_reg <= row_rdata_reg;
            end
            OP_MQ:  t2_reg <= mul_r[PRICE_W-1:0];
            OP_SUM: ev_reg <= sum_r[PRICE_W] ? {PRICE_W{1'b1}} : sum_r[PRICE_W-1:0];
            OP_DISC:
            begin
                down_reg <= up_reg;
                root_reg <= node_val;
            end
            default: ;
        endcase
    end

    // counters, saturation flag and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            lvl_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_flag_reg  <= 1'b0;
            out_value_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_START:
                begin
                    cnt_reg  <= '0;
                    lvl_reg  <= n_clamped;
                    flag_reg <= 1'b0;
                end
                OP_DOWN:
                begin
                    cnt_reg  <= cnt_reg + IDX_W'(1);
                    flag_reg <= flag_reg | mul_r[PRICE_W];
                end
                OP_DOWN_END: cnt_reg <= '0;
                OP_LEAF:     cnt_reg <= cnt_reg + IDX_W'(1);
                OP_UP, OP_MP, OP_MQ: flag_reg <= flag_reg | mul_r[PRICE_W];
                OP_LDEC:     lvl_reg <= lvl_reg - IDX_W'(1);
                OP_LV:       cnt_reg <= '0;
                OP_SUM:      flag_reg <= flag_reg | sum_r[PRICE_W];
                OP_DISC:
                begin
                    cnt_reg  <= cnt_reg + IDX_W'(1);
                    flag_reg <= flag_reg | mul_r[PRICE_W];
                end
                default: ;
            endcase

            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
                out_value_reg <= root_reg;
                out_flag_reg  <= flag_reg;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.cnt_eq_n   = (cnt_reg == n_reg);
    assign status.cnt_eq_lvl = (cnt_reg == lvl_reg);
    assign status.lvl_zero   = (lvl_reg == '0);
    assign status.american   = american;
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign option_value = out_value_reg;
    assign saturated    = out_flag_reg;

endmodule

// ===== hw/rtl/binomial_option_pricer.sv =====
// Cox-Ross-Rubinstein binomial lattice option pricer.
// Input channel: spot_price and strike_price (unsigned Q16.16) are taken
// when in_valid is high and in_stall is low. in_stall stays high while an
// item is being priced; one item is worked on at a time.
// Output channel: option_value (Q16.16) and saturated are held in an output
// register under out_valid until taken (out_valid high, out_stall low).
// A stalled result holds its value; the next item may be accepted meanwhile
// and waits at its end until the output register is free.
// Each item walks the price down to the bottom leaf, then builds the leaves
// from the bottom up, two up multiplies per leaf. Each level then rolls back
// node by node (read, p and q multiplies, sum, discount); american kinds also
// walk node prices up by two multiplies; one shared multiplier does them all.
// Configuration is written over the APB port at byte address 4*i; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset returns all configuration registers to their defaults (u = d = 1.0,
// p = 0.5, discount 1.0, N = 30, european call), clears the controller and
// drops any pending result. Value row memory is not cleared.
module binomial_option_pricer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] spot_price,
    input  logic [31:0] strike_price,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] option_value,
    output logic        saturated
);
    import bop_pkg::*;

    logic [31:0] up_factor_reg, down_factor_reg;
    logic [30:0] up_prob_reg, discount_reg;
    logic [10:0] step_count_reg;
    logic [1:0]  option_kind_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    dp_cmd_t     cmd;
    dp_status_t  status;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_factor_reg   <= 32'h4000_0000;
            down_factor_reg <= 32'h4000_0000;
            up_prob_reg     <= 31'h2000_0000;
            discount_reg    <= Q30_ONE;
            step_count_reg  <= STEP_COUNT_RESET;
            option_kind_reg <= KIND_EURO_CALL;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_UP_FACTOR:   up_factor_reg   <= pwdata;
                REG_DOWN_FACTOR: down_factor_reg <= pwdata;
                REG_UP_PROB:     up_prob_reg     <= pwdata[30:0];
                REG_DISCOUNT:    discount_reg    <= pwdata[30:0];
                REG_STEP_COUNT:  step_count_reg  <= pwdata[10:0];
                REG_OPTION_KIND: option_kind_reg <= pwdata[1:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // readback
    always_comb
    begin
        unique case (reg_idx)
            REG_UP_FACTOR:   prdata = up_factor_reg;
            REG_DOWN_FACTOR: prdata = down_factor_reg;
            REG_UP_PROB:     prdata = {1'b0, up_prob_reg};
            REG_DISCOUNT:    prdata = {1'b0, discount_reg};
            REG_STEP_COUNT:  prdata = {21'd0, step_count_reg};
            REG_OPTION_KIND: prdata = {30'd0, option_kind_reg};
            default:         prdata = '0;
        endcase
    end

    bop_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bop_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .spot_price     (spot_price),
        .strike_price   (strike_price),
        .up_factor      (up_factor_reg),
        .down_factor    (down_factor_reg),
        .up_probability (up_prob_reg),
        .step_discount  (discount_reg),
        .step_count     (step_count_reg),
        .option_kind    (option_kind_reg),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .option_value   (option_value),
        .saturated      (saturated)
    );

endmodule

// ===== hw/rtl/bop_checker.sv =====
module bop_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] option_value
);

    // busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while block still free");

    // no result can appear the cycle after an item is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !$rose(out_valid))
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(option_value))
        else $error("stalled result changed");

endmodule

bind binomial_option_pricer bop_checker u_bop_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .option_value (option_value)
);

// ===== tb/tb_binomial_option_pricer.sv =====
module tb_binomial_option_pricer;
    timeunit 1ns;
    timeprecision 1ps;

    import bop_pkg::*;

    // Cap on the run: one full-size european lattice costs by far the most,
    // everything else is small, so the limit leaves ample margin.
    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int HOLD_CYCLES = 4000;

    typedef struct {
        logic [31:0] value;
        logic        sat;
    } priced_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] spot_price;
    logic [31:0] strike_price;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] option_value;
    logic        saturated;

    // Mirror of the block's registers, kept in step with every APB write.
    logic [31:0] cfg_up;
    logic [31:0] cfg_down;
    logic [30:0] cfg_prob;
    logic [30:0] cfg_disc;
    logic [10:0] cfg_steps;
    logic [1:0]  cfg_kind;

    logic [31:0] lattice_row [0:MAX_STEPS];
    bit          clip_seen;
    priced_t     pending_prices[$];

    int mismatch_count;
    int priced_count;
    int cycle_count;
    int burst_left;
    int hold_len;
    bit stall_on;

    binomial_option_pricer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .spot_price   (spot_price),
        .strike_price (strike_price),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .option_value (option_value),
        .saturated    (saturated)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ---------------------------------------------------------------
    // Predictor: fixed-point lattice, same rounding and clipping rules
    // as the block. clip_seen collects any saturation within one item.
    // ---------------------------------------------------------------
    function automatic logic [31:0] clip_price(logic [32:0] v);
        if (v > 33'hFFFF_FFFF)
        begin
            clip_seen = 1'b1;
            return 32'hFFFF_FFFF;
        end
        return v[31:0];
    endfunction

    // round half up of a * b / 2^30, then clip to the price width
    function automatic logic [31:0] q30_mul(logic [31:0] a, logic [31:0] b);
        logic [65:0] prod;
        prod = (66'(a) * 66'(b)) + (66'd1 << 29);
        prod = prod >> 30;
        if (prod > 66'hFFFF_FFFF)
        begin
            clip_seen = 1'b1;
            return 32'hFFFF_FFFF;
        end
        return prod[31:0];
    endfunction

    function automatic logic [31:0] exercise_value(logic [31:0] price, logic [31:0] strike,
                                                   bit is_put);
        if (is_put)
            return (strike > price) ? strike - price : 32'd0;
        return (price > strike) ? price - strike : 32'd0;
    endfunction

    function automatic logic [31:0] lowest_price(logic [31:0] spot, int level);
        logic [31:0] p;
        p = spot;
        for (int i = 0; i < level; i++)
            p = q30_mul(p, cfg_down);
        return p;
    endfunction

    function automatic priced_t price_option(logic [31:0] spot, logic [31:0] strike);
        priced_t     res;
        int          steps;
        bit          is_put;
        bit          early;
        logic [31:0] prob;
        logic [31:0] prob_down;
        logic [31:0] node;
        logic [31:0] hold;
        logic [31:0] ex;
        logic [32:0] sum;
        clip_seen = 1'b0;
        is_put = (cfg_kind == KIND_EURO_PUT) || (cfg_kind == KIND_AMER_PUT);
        early  = (cfg_kind == KIND_AMER_CALL) || (cfg_kind == KIND_AMER_PUT);
        steps = cfg_steps;
        if (steps == 0)
            steps = 1;
        if (steps > MAX_STEPS)
            steps = MAX_STEPS;
        prob = (cfg_prob > Q30_ONE) ? 32'(Q30_ONE) : 32'(cfg_prob);
        prob_down = 32'(Q30_ONE) - prob;

        // leaves, bottom node first
        node = lowest_price(spot, steps);
        for (int j = 0; j <= steps; j++)
        begin
            lattice_row[j] = exercise_value(node, strike, is_put);
            if (j < steps)
                node = q30_mul(q30_mul(node, cfg_up), cfg_up);
        end

        // roll back in place
        for (int lvl = steps - 1; lvl >= 0; lvl--)
        begin
            if (early)
                node = lowest_price(spot, lvl);
            for (int j = 0; j <= lvl; j++)
            begin
                sum = 33'(q30_mul(lattice_row[j + 1], prob))
                    + 33'(q30_mul(lattice_row[j], prob_down));
                hold = q30_mul(clip_price(sum), 32'(cfg_disc));
                if (early)
                begin
                    ex = exercise_value(node, strike, is_put);
                    if (ex > hold)
                        hold = ex;
                    if (j < lvl)
                        node = q30_mul(q30_mul(node, cfg_up), cfg_up);
                end
                lattice_row[j] = hold;
            end
        end
        res.value = lattice_row[0];
        res.sat   = clip_seen;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Register access
    // ---------------------------------------------------------------
    task automatic write_reg(logic [2:0] index, logic [31:0] data);
        // setup phase, then access phase; write lands when penable is high
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_UP_FACTOR:   cfg_up    = data;
            REG_DOWN_FACTOR: cfg_down  = data;
            REG_UP_PROB:     cfg_prob  = data[30:0];
            REG_DISCOUNT:    cfg_disc  = data[30:0];
            REG_STEP_COUNT:  cfg_steps = data[10:0];
            REG_OPTION_KIND: cfg_kind  = data[1:0];
            default: ;
        endcase
    endtask

    task automatic load_lattice(logic [31:0] up, logic [31:0] down, logic [31:0] prob,
                                logic [31:0] disc, logic [31:0] steps, logic [1:0] kind);
        write_reg(REG_UP_FACTOR, up);
        write_reg(REG_DOWN_FACTOR, down);
        write_reg(REG_UP_PROB, prob);
        write_reg(REG_DISCOUNT, disc);
        write_reg(REG_STEP_COUNT, steps);
        write_reg(REG_OPTION_KIND, {30'd0, kind});
    endtask

    // ---------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps. Valid is
    // only lowered when a gap follows, never dropped and raised in one step.
    // ---------------------------------------------------------------
    task automatic send_item(logic [31:0] spot, logic [31:0] strike, bit no_gap = 1'b0);
        int gap;
        if (!no_gap && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        in_valid     <= 1'b1;
        spot_price   <= spot;
        strike_price <= strike;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_prices.push_back(price_option(spot, strike));
    endtask

    // Drop valid and let every outstanding result come back; needed before
    // any register write.
    task automatic drain;
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_prices.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [31:0] near_one(int spread);
        return 32'h4000_0000 + $urandom_range(0, spread) - spread / 2;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_reset_defaults;
        // defaults: flat lattice, N = 30, european call
        send_item(32'h0012_0000, 32'h0010_0000);
        send_item(32'h0000_0000, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'h0000_0000);
        drain();
    endtask

    task automatic test_option_kinds;
        // each kind on a small growing lattice, in and out of the money
        for (int k = 0; k < 4; k++)
        begin
            load_lattice(32'h4400_0000, 32'h3C3C_3C3C, 32'h2000_0000 + 32'h0100_0000,
                         32'h3FF0_0000, 8, k[1:0]);
            send_item(32'h0064_0000, 32'h005A_0000);
            send_item(32'h0064_0000, 32'h0070_0000);
            drain();
        end
    endtask

    task automatic test_edge_settings;
        // zero steps behaves as one step
        load_lattice(32'h4800_0000, 32'h3800_0000, 32'h2000_0000, 32'h4000_0000, 0,
                     KIND_EURO_PUT);
        send_item(32'h0050_0000, 32'h0060_0000);
        drain();
        // single step, probability above one (clamped), american call
        load_lattice(32'h5000_0000, 32'h3000_0000, 32'h7FFF_FFFF, 32'h3F00_0000, 1,
                     KIND_AMER_CALL);
        send_item(32'h0050_0000, 32'h0010_0000);
        drain();
        // discount above one and huge factors drive saturation
        load_lattice(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 6,
                     KIND_AMER_PUT);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'h8000_0001, 32'h0000_0001);
        drain();
        write_reg(REG_OPTION_KIND, {30'd0, KIND_EURO_CALL});
        send_item(32'hFFFF_FFFF, 32'h0000_0000);
        drain();
        // exact extremes of probability and discount
        load_lattice(32'h4200_0000, 32'h3E00_0000, 32'h4000_0000, 32'h0000_0000, 3,
                     KIND_EURO_CALL);
        send_item(32'h1234_5678, 32'h0100_0000);
        drain();
    endtask

    task automatic test_largest_lattice;
        // step count above the maximum is clamped to the full lattice size
        load_lattice(32'h4010_0000, 32'h3FF0_0400, 32'h2008_0000, 32'h3FFF_F000,
                     32'h7FF, KIND_EURO_CALL);
        send_item(32'h0064_0000, 32'h0064_0000);
        drain();
    endtask

    task automatic test_backpressure;
        // hold off the receiver while items keep coming, so the result
        // register and then the input side back up
        load_lattice(32'h4400_0000, 32'h3C00_0000, 32'h2000_0000, 32'h3FC0_0000, 4,
                     KIND_EURO_PUT);
        hold_len = HOLD_CYCLES;
        repeat (6)
            send_item($urandom, $urandom, 1'b1);
        drain();
    endtask

    task automatic test_random_lattices;
        logic [31:0] spot;
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase == 4)
                load_lattice($urandom, $urandom, $urandom, $urandom,
                             $urandom_range(0, 12), $urandom_range(0, 3));
            else
                load_lattice(near_one(32'h1000_0000) | 32'h4000_0000,
                             near_one(32'h1000_0000) & 32'h3FFF_FFFF,
                             $urandom_range(0, 32'h4000_0000),
                             $urandom_range(32'h3800_0000, 32'h4000_0000),
                             $urandom_range(1, 24), phase[1:0]);
            for (int i = 0; i < 16; i++)
            begin
                spot = ($urandom_range(0, 4) == 0) ? $urandom
                                                   : $urandom_range(1, 32'h0400_0000);
                if ($urandom_range(0, 4) == 0)
                    send_item(spot, $urandom);
                else
                    send_item(spot, spot + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
            end
            drain();
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver stall: random stalls in on/off stretches, plus a long hold
    // counted here when a test asks for one.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_len > 0)
        begin
            out_stall <= 1'b1;
            hold_len  <= hold_len - 1;
        end
        else
        begin
            if ($urandom_range(0, 150) == 0)
                stall_on <= ~stall_on;
            out_stall <= stall_on && ($urandom_range(0, 2) != 0);
        end
    end

    // Result checker: compare each taken result with the oldest prediction.
    always @(posedge clk)
    begin
        priced_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_prices.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual value %h sat %b",
                         $time, option_value, saturated);
                mismatch_count++;
            end
            else
            begin
                want = pending_prices.pop_front();
                priced_count++;
                if (option_value !== want.value)
                begin
                    $display("%0t: option_value: expected %h, actual %h",
                             $time, want.value, option_value);
                    mismatch_count++;
                end
                if (saturated !== want.sat)
                begin
                    $display("%0t: saturated: expected %b, actual %b",
                             $time, want.sat, saturated);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        spot_price   = '0;
        strike_price = '0;
        out_stall    = 1'b0;
        stall_on     = 1'b0;
        hold_len     = 0;
        burst_left   = 0;
        cycle_count  = 0;
        mismatch_count = 0;
        priced_count = 0;
        cfg_up    = 32'h4000_0000;
        cfg_down  = 32'h4000_0000;
        cfg_prob  = 31'h2000_0000;
        cfg_disc  = 31'h4000_0000;
        cfg_steps = STEP_COUNT_RESET;
        cfg_kind  = KIND_EURO_CALL;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_option_kinds();
        test_edge_settings();
        test_backpressure();
        test_random_lattices();
        test_largest_lattice();

        drain();
        $display("Priced %0d items over all four option kinds, clamped step counts,",
                 priced_count);
        $display("saturating settings, a full-size lattice and a long output hold-off.");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
